/* rtl/floating_horizon_surface_plotter_macros.svh */
// assertion helpers shared by the plotter modules
// both expect clk and rst_n in scope
`ifndef FLOATING_HORIZON_SURFACE_PLOTTER_MACROS_SVH
`define FLOATING_HORIZON_SURFACE_PLOTTER_MACROS_SVH

// same-cycle implication
`define FHSP_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FHSP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fhsp_pkg.sv */
package fhsp_pkg;

  // input kind codes
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // config register indexes
  localparam logic [2:0] REG_GAIN_X     = 3'd0;
  localparam logic [2:0] REG_GAIN_Y     = 3'd1;
  localparam logic [2:0] REG_GAIN_Z     = 3'd2;
  localparam logic [2:0] REG_CENTER_COL = 3'd3;
  localparam logic [2:0] REG_CENTER_ROW = 3'd4;

  localparam int CFG_AW = 5;

  // register reset values
  localparam logic [9:0]  GAIN_X_RST     = 10'd40;
  localparam logic [9:0]  GAIN_Y_RST     = 10'd40;
  localparam logic [11:0] GAIN_Z_RST     = 12'd400;
  localparam logic [10:0] CENTER_COL_RST = 11'd960;
  localparam logic [10:0] CENTER_ROW_RST = 11'd540;

  // cos 30 in q0.16
  localparam logic [16:0] COS30_Q16 = 17'd56756;

  localparam int HZ_W = 12;
  localparam logic signed [HZ_W-1:0] ROW_MIN = -12'sd2048;
  localparam logic signed [HZ_W-1:0] ROW_MAX = 12'sd2047;

  typedef struct packed {
    logic [9:0]  gain_x;
    logic [9:0]  gain_y;
    logic [11:0] gain_z;
    logic [10:0] center_col;
    logic [10:0] center_row;
  } cfg_t;

  typedef struct packed {
    logic capture;    // latch input beat
    logic hz_rd;      // read horizon at projected column
    logic commit;     // update horizon if point visible
    logic sweep_wr;   // clearing sweep write
    logic res_ld;     // load result register
    logic res_blank;  // result is a non-drawing beat
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
  } sts_t;

endpackage

/* rtl/fhsp_in_if.sv */
interface fhsp_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  logic signed [15:0] height;

  modport source (output valid, kind, x_coord, y_coord, height, input ready);
  modport sink (input valid, kind, x_coord, y_coord, height, output ready);
endinterface

/* rtl/fhsp_out_if.sv */
interface fhsp_out_if;
  logic        valid;
  logic        ready;
  logic        draw;
  logic [10:0] column;
  logic [10:0] row;

  modport source (output valid, draw, column, row, input ready);
  modport sink (input valid, draw, column, row, output ready);
endinterface

/* rtl/fhsp_cfg.sv */
module fhsp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fhsp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output fhsp_pkg::cfg_t              cfg_o
);

  logic [9:0]  gain_x_r;
  logic [9:0]  gain_y_r;
  logic [11:0] gain_z_r;
  logic [10:0] center_col_r;
  logic [10:0] center_row_r;
  logic [2:0]  idx;
  logic        wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[fhsp_pkg::CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_x_r     <= fhsp_pkg::GAIN_X_RST;
      gain_y_r     <= fhsp_pkg::GAIN_Y_RST;
      gain_z_r     <= fhsp_pkg::GAIN_Z_RST;
      center_col_r <= fhsp_pkg::CENTER_COL_RST;
      center_row_r <= fhsp_pkg::CENTER_ROW_RST;
    end else if (wr_en) begin
      case (idx)
        fhsp_pkg::REG_GAIN_X:     gain_x_r     <= pwdata[9:0];
        fhsp_pkg::REG_GAIN_Y:     gain_y_r     <= pwdata[9:0];
        fhsp_pkg::REG_GAIN_Z:     gain_z_r     <= pwdata[11:0];
        fhsp_pkg::REG_CENTER_COL: center_col_r <= pwdata[10:0];
        fhsp_pkg::REG_CENTER_ROW: center_row_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fhsp_pkg::REG_GAIN_X:     prdata = {22'd0, gain_x_r};
      fhsp_pkg::REG_GAIN_Y:     prdata = {22'd0, gain_y_r};
      fhsp_pkg::REG_GAIN_Z:     prdata = {20'd0, gain_z_r};
      fhsp_pkg::REG_CENTER_COL: prdata = {21'd0, center_col_r};
      fhsp_pkg::REG_CENTER_ROW: prdata = {21'd0, center_row_r};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{gain_x:     gain_x_r,
                   gain_y:     gain_y_r,
                   gain_z:     gain_z_r,
                   center_col: center_col_r,
                   center_row: center_row_r};

endmodule

/* rtl/fhsp_dp.sv */
`include "floating_horizon_surface_plotter_macros.svh"

module fhsp_dp #(
  parameter int COLUMNS = 1920,
  parameter int ROWS    = 1080
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fhsp_pkg::cfg_t     cfg_i,
  input  fhsp_pkg::cmd_t     cmd,
  output fhsp_pkg::sts_t     sts,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic signed [15:0] height,
  output logic               draw,
  output logic [10:0]        column,
  output logic [10:0]        row
);

  localparam int AW = $clog2(COLUMNS);
  localparam int HW = fhsp_pkg::HZ_W;

  logic signed [15:0] x_r, y_r, z_r;
  logic signed [26:0] gx_r, gy_r;
  logic signed [28:0] gz_r;
  logic signed [27:0] diff_r;
  logic signed [34:0] racc_r;
  logic signed [45:0] prod_r;
  logic signed [HW-1:0] row_r;
  logic signed [22:0] col_r;
  logic signed [HW-1:0] hz_rd_r;
  logic [AW-1:0] sweep_addr_r;
  logic res_draw_r;
  logic [10:0] res_col_r, res_row_r;

  logic signed [HW-1:0] hz_mem [COLUMNS];

  logic signed [27:0] sum;
  logic signed [34:0] racc_nxt, radj;
  logic signed [20:0] rq;
  logic signed [HW-1:0] row_nxt;
  logic signed [46:0] cacc, cadj;
  logic col_ok, visible, vis_draw, hz_we_pt, hz_we;
  logic [AW-1:0] hz_waddr;
  logic signed [HW-1:0] hz_wdata;

  // row accumulator in q.14
  always_comb begin
    sum      = 28'(gy_r) + 28'(gx_r);
    racc_nxt = 35'($signed({1'b0, cfg_i.center_row, 14'd0})) + (35'(sum) <<< 5)
               - 35'(gz_r);
  end

  // truncate row toward zero, then saturate
  always_comb begin
    radj = racc_r + (racc_r[34] ? 35'sd16383 : 35'sd0);
    rq   = radj[34:14];
    if (rq < 21'(fhsp_pkg::ROW_MIN)) begin
      row_nxt = fhsp_pkg::ROW_MIN;
    end else if (rq > 21'(fhsp_pkg::ROW_MAX)) begin
      row_nxt = fhsp_pkg::ROW_MAX;
    end else begin
      row_nxt = rq[HW-1:0];
    end
  end

  // column in q.24, truncated toward zero
  always_comb begin
    cacc = 47'($signed({1'b0, cfg_i.center_col, 24'd0})) + 47'(prod_r);
    cadj = cacc + (cacc[46] ? 47'sd16777215 : 47'sd0);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= x_coord;
      y_r <= y_coord;
      z_r <= height;
    end
    gx_r   <= 27'(x_r) * 27'($signed({1'b0, cfg_i.gain_x}));
    gy_r   <= 27'(y_r) * 27'($signed({1'b0, cfg_i.gain_y}));
    gz_r   <= 29'(z_r) * 29'($signed({1'b0, cfg_i.gain_z}));
    diff_r <= 28'(gy_r) - 28'(gx_r);
    racc_r <= racc_nxt;
    prod_r <= 46'(diff_r) * 46'($signed({1'b0, fhsp_pkg::COS30_Q16}));
    row_r  <= row_nxt;
    col_r  <= cadj[46:24];
  end

  assign col_ok   = !col_r[22] && (col_r < $signed(23'(COLUMNS)));
  assign visible  = col_ok && (row_r < hz_rd_r);
  assign vis_draw = visible && !row_r[HW-1] && (row_r < $signed(12'(ROWS)));
  assign hz_we_pt = cmd.commit && visible;
  assign hz_we    = hz_we_pt || cmd.sweep_wr;
  assign hz_waddr = cmd.sweep_wr ? sweep_addr_r : col_r[AW-1:0];
  assign hz_wdata = cmd.sweep_wr ? $signed(12'(ROWS)) : row_r;

  // horizon memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (hz_we) begin
      hz_mem[hz_waddr] <= hz_wdata;
    end
    if (cmd.hz_rd) begin
      hz_rd_r <= hz_mem[col_r[AW-1:0]];
    end
  end

  assign sts.sweep_last = (sweep_addr_r == AW'(COLUMNS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_addr_r <= sts.sweep_last ? '0 : sweep_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      if (cmd.res_blank || !vis_draw) begin
        res_draw_r <= 1'b0;
        res_col_r  <= '0;
        res_row_r  <= '0;
      end else begin
        res_draw_r <= 1'b1;
        res_col_r  <= col_r[10:0];
        res_row_r  <= row_r[10:0];
      end
    end
  end

  assign draw   = res_draw_r;
  assign column = res_col_r;
  assign row    = res_row_r;

  `FHSP_CHECK(a_sweep_range, 1'b1, sweep_addr_r <= AW'(COLUMNS - 1), "sweep address past last column")
  `FHSP_CHECK(a_point_write_onscreen, hz_we_pt, col_ok && !cmd.sweep_wr, "horizon write off screen")
  `FHSP_CHECK_NEXT(a_blank_result, cmd.res_ld && cmd.res_blank, !res_draw_r, "clear beat drew a pixel")

endmodule

/* rtl/fhsp_ctrl.sv */
`include "floating_horizon_surface_plotter_macros.svh"

module fhsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid_i,
  input  logic           in_kind_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fhsp_pkg::cmd_t cmd,
  input  fhsp_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_PROD,
    ST_COL,
    ST_READ,
    ST_DONE,
    ST_CLEAR,
    ST_CLR_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  assign slot_free  = !out_valid_r || out_ready_i;
  assign in_ready_o = (state_r == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.capture = accept;
        if (accept) begin
          state_nxt = (in_kind_i == fhsp_pkg::KIND_CLEAR) ? ST_CLEAR : ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_COL;
      ST_COL:  state_nxt = ST_READ;
      ST_READ: begin
        cmd.hz_rd = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          cmd.res_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_nxt = ST_CLR_OUT;
      end
      ST_CLR_OUT: begin
        if (slot_free) begin
          cmd.res_ld    = 1'b1;
          cmd.res_blank = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid_o = out_valid_r;

  `FHSP_CHECK(a_res_slot_free, cmd.res_ld, !out_valid_r || out_ready_i, "result loaded over a waiting beat")
  `FHSP_CHECK_NEXT(a_accept_leaves_idle, accept, state_r != ST_IDLE, "accepted beat left block idle")
  `FHSP_CHECK(a_idle_quiet, state_r == ST_IDLE, !cmd.sweep_wr && !cmd.commit && !cmd.res_ld, "datapath driven while idle")

endmodule

/* rtl/floating_horizon_surface_plotter.sv */
// point beat: the projection stages (gain products, sums, cos 30 product, column) and
// the registered horizon read, then result; clear beat: COLUMNS horizon writes then result
// by the one-column-per-cycle sweep; the result is loaded once the result register is free,
// and the next beat is taken after the result is loaded
// reset (rst_n low, synchronous): control and config registers to defaults, then a sweep
// sets every horizon entry to ROWS; no input beat is taken during the sweep
module floating_horizon_surface_plotter #(
  parameter int COLUMNS = 1920,
  parameter int ROWS    = 1080
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fhsp_in_if.sink                     in_bus,
  fhsp_out_if.source                  out_bus,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [fhsp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  // gains and screen center, written over apb; the user must write them only while idle, the block does not enforce it
  fhsp_pkg::cfg_t cfg;
  // controller to datapath commands and the status coming back
  fhsp_pkg::cmd_t cmd;
  fhsp_pkg::sts_t sts;

  fhsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg)
  );

  // sequencer: one beat at a time, the result register lets the next
  // beat start while the previous result waits for the sink
  fhsp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_bus.valid),
    .in_kind_i   (in_bus.kind),
    .in_ready_o  (in_bus.ready),
    .out_valid_o (out_bus.valid),
    .out_ready_i (out_bus.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  // datapath: projection pipeline (gain products, sums, cos 30 product,
  // truncation and saturation), horizon memory and the result register
  fhsp_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg),
    .cmd     (cmd),
    .sts     (sts),
    .x_coord (in_bus.x_coord),
    .y_coord (in_bus.y_coord),
    .height  (in_bus.height),
    .draw    (out_bus.draw),
    .column  (out_bus.column),
    .row     (out_bus.row)
  );

endmodule
